FILE: src/owrm_pkg.sv
// Shared types, constants and CRC helper for the one-wire ROM read master.
// No dependencies; used by every module of the block.
package owrm_pkg;

  // Number of ROM bytes read after the command (last byte is the CRC).
  localparam int ROM_BYTES = 8;

  localparam logic [6:0] ROM_BITS = 7'(ROM_BYTES * 8);
  localparam logic [6:0] CRC_BITS = 7'((ROM_BYTES - 1) * 8);
  localparam int         LAST_SH  = ((ROM_BYTES - 1) * 8) % 64;
  localparam logic [6:0] CMD_LAST = 7'd7;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] LOW_MAX  = 8'hFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PRES  = 2'd1;
  localparam logic [1:0] ST_CRC_FAIL = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RESET    = 4'd1,
    PH_PRESENCE = 4'd2,
    PH_PAUSE    = 4'd3,
    PH_WLOW     = 4'd4,
    PH_WHIGH    = 4'd5,
    PH_RSAMPLE  = 4'd6,
    PH_RRECOVER = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_PRES_WINDOW = 3'd1,
    CFG_PAUSE       = 3'd2,
    CFG_SHORT_PHASE = 3'd3,
    CFG_LONG_PHASE  = 3'd4,
    CFG_SAMPLE      = 3'd5,
    CFG_RECOVERY    = 3'd6,
    CFG_THRESHOLD   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_window_ticks;
    logic [15:0] pause_ticks;
    logic [15:0] short_phase_ticks;
    logic [15:0] long_phase_ticks;
    logic [7:0]  sample_ticks;
    logic [15:0] recovery_ticks;
    logic [7:0]  low_count_threshold;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [7:0] cmd;
    logic       line_in;
  } req_t;

  typedef struct packed {
    logic        drive_low;
    logic        done_res;
    logic [1:0]  status;
    logic [63:0] rom_code;
  } res_t;

  // One step of the reflected CRC-8 (x^8+x^5+x^4+1), LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic b);
    logic [7:0] c;
    c = {1'b0, crc[7:1]};
    if (crc[0] ^ b) begin
      c = c ^ CRC_POLY;
    end
    return c;
  endfunction

endpackage

FILE: src/owrm_cfg.sv
// Timing register file of the one-wire ROM read master.
// Depends on owrm_pkg for the register index codes and the cfg_t struct.
module owrm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output owrm_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks       <= 16'd480;
      cfg.presence_window_ticks <= 16'd240;
      cfg.pause_ticks           <= 16'd240;
      cfg.short_phase_ticks     <= 16'd6;
      cfg.long_phase_ticks      <= 16'd60;
      cfg.sample_ticks          <= 8'd15;
      cfg.recovery_ticks        <= 16'd5;
      cfg.low_count_threshold   <= 8'd7;
    end else if (cfg_write_en) begin
      unique case (owrm_pkg::cfg_idx_t'(cfg_index))
        owrm_pkg::CFG_RESET_LOW:   cfg.reset_low_ticks       <= cfg_data;
        owrm_pkg::CFG_PRES_WINDOW: cfg.presence_window_ticks <= cfg_data;
        owrm_pkg::CFG_PAUSE:       cfg.pause_ticks           <= cfg_data;
        owrm_pkg::CFG_SHORT_PHASE: cfg.short_phase_ticks     <= cfg_data;
        owrm_pkg::CFG_LONG_PHASE:  cfg.long_phase_ticks      <= cfg_data;
        owrm_pkg::CFG_SAMPLE:      cfg.sample_ticks          <= cfg_data[7:0];
        owrm_pkg::CFG_RECOVERY:    cfg.recovery_ticks        <= cfg_data;
        owrm_pkg::CFG_THRESHOLD:   cfg.low_count_threshold   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/owrm_core.sv
// Bus sequencer and receive datapath: one tick of the waveform per request.
// Depends on owrm_pkg for phases, structs, constants and the CRC step.
module owrm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  owrm_pkg::cfg_t      cfg,
  input  owrm_pkg::req_t      req,
  output owrm_pkg::res_t      res
);

  owrm_pkg::phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [6:0]  bit_index, bit_index_next;
  logic [7:0]  low_count, low_count_next;
  logic [7:0]  command_shift, command_shift_next;
  logic [63:0] rom_shift, rom_shift_next;
  logic [7:0]  crc_reg, crc_reg_next;

  logic [15:0] phase_len;
  logic [15:0] tick_inc;
  logic        over;
  logic        rd_last;
  logic [6:0]  pos;
  logic        bitval;
  logic [63:0] rom_set;
  logic [7:0]  crc_upd;

  // length of the current phase
  always_comb begin
    unique case (phase)
      owrm_pkg::PH_RESET:    phase_len = cfg.reset_low_ticks;
      owrm_pkg::PH_PRESENCE: phase_len = cfg.presence_window_ticks;
      owrm_pkg::PH_PAUSE:    phase_len = cfg.pause_ticks;
      owrm_pkg::PH_WLOW:     phase_len = command_shift[0] ? cfg.short_phase_ticks
                                                          : cfg.long_phase_ticks;
      owrm_pkg::PH_WHIGH:    phase_len = command_shift[0] ? cfg.long_phase_ticks
                                                          : cfg.short_phase_ticks;
      owrm_pkg::PH_RSAMPLE:  phase_len = {8'd0, cfg.sample_ticks};
      owrm_pkg::PH_RRECOVER: phase_len = cfg.recovery_ticks;
      default:               phase_len = 16'd1;
    endcase
  end

  assign tick_inc = tick_count + 16'd1;
  assign over     = (tick_inc >= phase_len);
  assign rd_last  = (bit_index >= owrm_pkg::ROM_BITS);

  // read bit decode and CRC
  assign pos     = bit_index - 7'd1;
  assign bitval  = !(low_count > cfg.low_count_threshold);
  assign rom_set = rom_shift | (64'(bitval) << pos[5:0]);
  assign crc_upd = owrm_pkg::crc8_step(crc_reg, bitval);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      owrm_pkg::PH_IDLE: begin
        if (req.start_req) phase_next = owrm_pkg::PH_RESET;
      end
      owrm_pkg::PH_RESET: begin
        if (over) phase_next = owrm_pkg::PH_PRESENCE;
      end
      owrm_pkg::PH_PRESENCE: begin
        if (!req.line_in) begin
          phase_next = (cfg.pause_ticks == 16'd0) ? owrm_pkg::PH_WLOW
                                                  : owrm_pkg::PH_PAUSE;
        end else if (over) begin
          phase_next = owrm_pkg::PH_IDLE;
        end
      end
      owrm_pkg::PH_PAUSE: begin
        if (over) phase_next = owrm_pkg::PH_WLOW;
      end
      owrm_pkg::PH_WLOW: begin
        if (over) phase_next = owrm_pkg::PH_WHIGH;
      end
      owrm_pkg::PH_WHIGH: begin
        if (over) begin
          phase_next = (bit_index >= owrm_pkg::CMD_LAST) ? owrm_pkg::PH_RSAMPLE
                                                        : owrm_pkg::PH_WLOW;
        end
      end
      owrm_pkg::PH_RSAMPLE: begin
        if (over) phase_next = owrm_pkg::PH_RRECOVER;
      end
      owrm_pkg::PH_RRECOVER: begin
        if (over) phase_next = rd_last ? owrm_pkg::PH_IDLE : owrm_pkg::PH_RSAMPLE;
      end
      default: phase_next = owrm_pkg::PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    low_count_next     = low_count;
    command_shift_next = command_shift;
    rom_shift_next     = rom_shift;
    crc_reg_next       = crc_reg;
    res                = '0;
    unique case (phase)
      owrm_pkg::PH_IDLE: begin
        if (req.start_req) begin
          command_shift_next = req.cmd;
          rom_shift_next     = '0;
          crc_reg_next       = '0;
          bit_index_next     = '0;
          low_count_next     = '0;
          tick_count_next    = '0;
        end
      end
      owrm_pkg::PH_RESET: begin
        res.drive_low   = 1'b1;
        tick_count_next = over ? 16'd0 : tick_inc;
      end
      owrm_pkg::PH_PRESENCE: begin
        if (!req.line_in) begin
          tick_count_next = '0;
        end else begin
          tick_count_next = over ? 16'd0 : tick_inc;
          if (over) begin
            res.done_res = 1'b1;
            res.status   = owrm_pkg::ST_NO_PRES;
          end
        end
      end
      owrm_pkg::PH_PAUSE: begin
        tick_count_next = over ? 16'd0 : tick_inc;
      end
      owrm_pkg::PH_WLOW: begin
        res.drive_low   = 1'b1;
        tick_count_next = over ? 16'd0 : tick_inc;
      end
      owrm_pkg::PH_WHIGH: begin
        tick_count_next = over ? 16'd0 : tick_inc;
        if (over) begin
          command_shift_next = {1'b0, command_shift[7:1]};
          if (bit_index >= owrm_pkg::CMD_LAST) begin
            bit_index_next = '0;
            low_count_next = '0;
          end else begin
            bit_index_next = bit_index + 7'd1;
          end
        end
      end
      owrm_pkg::PH_RSAMPLE: begin
        tick_count_next = over ? 16'd0 : tick_inc;
        if (!req.line_in && low_count != owrm_pkg::LOW_MAX) begin
          low_count_next = low_count + 8'd1;
        end
      end
      owrm_pkg::PH_RRECOVER: begin
        res.drive_low   = 1'b1;
        tick_count_next = over ? 16'd0 : tick_inc;
        if (over) begin
          // slot 0 is the dummy slot: nothing recorded
          if (bit_index != 7'd0) begin
            rom_shift_next = rom_set;
            if (pos < owrm_pkg::CRC_BITS) crc_reg_next = crc_upd;
          end
          low_count_next = '0;
          if (rd_last) begin
            bit_index_next = '0;
            res.done_res   = 1'b1;
            res.status     = (rom_set[owrm_pkg::LAST_SH +: 8] == crc_reg)
                             ? owrm_pkg::ST_OK : owrm_pkg::ST_CRC_FAIL;
            res.rom_code   = rom_set;
          end else begin
            bit_index_next = bit_index + 7'd1;
          end
        end
      end
      default: begin
        tick_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owrm_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      low_count     <= '0;
      command_shift <= '0;
      rom_shift     <= '0;
      crc_reg       <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      low_count     <= low_count_next;
      command_shift <= command_shift_next;
      rom_shift     <= rom_shift_next;
      crc_reg       <= crc_reg_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == owrm_pkg::PH_IDLE)
    else $error("finished transaction did not return to idle");

  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    bit_index <= owrm_pkg::ROM_BITS)
    else $error("bit index ran past the ROM length");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    res.status != owrm_pkg::ST_OK || res.rom_code != 64'd0 |-> res.done_res)
    else $error("status or ROM code shown without done");

endmodule

FILE: src/onewire_read_rom_master_top.sv
// The result for a request sits in the output register in the cycle after acceptance.
// Throughput: one request (one bus tick) per cycle while out_stall is low; the output
// register frees in the same cycle it is taken, so requests flow back to back.
// Reset (rst, synchronous, high): sequencer idle, counters and shifters cleared, timing
// registers back to their defaults, output register empty.
// Depends on owrm_pkg, owrm_cfg and owrm_core.
module onewire_read_rom_master_top (
  input  logic                clk,
  input  logic                rst,
  // request channel: one bus tick
  input  logic                in_valid,
  output logic                in_stall,
  input  owrm_pkg::req_t      in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output owrm_pkg::res_t      out_data,
  // timing register writes
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  owrm_pkg::cfg_t cfg;
  owrm_pkg::res_t res;
  logic           step;

  owrm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // A request is taken whenever the output register is empty or being drained.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  owrm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .req  (in_data),
    .res  (res)
  );

  // Output register: loads on every accepted request, holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule
